// File: rtl/numeric_literal_classifier_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the numeric literal classifier
// Short forms for the concurrent checks. Every check is clocked on clock.
// ---------------------------------------------------------------------------
`ifndef NUMERIC_LITERAL_CLASSIFIER_UNIT_MACROS_SVH
`define NUMERIC_LITERAL_CLASSIFIER_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define NLC_ASSERT_IMPLY(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("numeric literal classifier check failed");

// Next-cycle implication, off while reset is high.
`define NLC_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("numeric literal classifier check failed");

// Next-cycle implication that is also checked while reset is high.
`define NLC_ASSERT_NEXT_ALWAYS(name, ante, cons) \
   name: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("numeric literal classifier check failed");

`endif

// File: rtl/nlc_pkg.sv
// ---------------------------------------------------------------------------
// nlc_pkg
// Types and constants shared by the numeric literal classifier modules.
// ---------------------------------------------------------------------------
package nlc_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      INT_START = 4'd0,
      INT_ZERO  = 4'd1,
      INT_HEX   = 4'd2,
      INT_BIN   = 4'd3,
      INT_OCT   = 4'd4,
      INT_DEC   = 4'd5,
      INT_U     = 4'd6,
      INT_UL    = 4'd7,
      INT_L     = 4'd8,
      INT_LL    = 4'd9,
      INT_END   = 4'd10,
      INT_DEAD  = 4'd11
   } int_phase_type;

   typedef enum logic [2:0] {
      FIX_BODY = 3'd0,
      FIX_U    = 3'd1,
      FIX_LH   = 3'd2,
      FIX_KR   = 3'd3,
      FIX_DEAD = 3'd4
   } fix_phase_type;

   typedef enum logic [3:0] {
      FLT_START     = 4'd0,
      FLT_ZERO      = 4'd1,
      FLT_DINT      = 4'd2,
      FLT_DFRAC     = 4'd3,
      FLT_HINT      = 4'd4,
      FLT_HFRAC     = 4'd5,
      FLT_EXP0      = 4'd6,
      FLT_EXP       = 4'd7,
      FLT_L         = 4'd8,
      FLT_LL        = 4'd9,
      FLT_FIN       = 4'd10,
      FLT_DEAD      = 4'd11,
      FLT_BODY_DONE = 4'd12
   } flt_phase_type;

   typedef enum logic [1:0] {
      CLASS_INT     = 2'd0,
      CLASS_FIX     = 2'd1,
      CLASS_FLT     = 2'd2,
      CLASS_INVALID = 2'd3
   } lit_class_type;

   // Pre-decoded character; letter flags are case insensitive.
   typedef struct packed {
      logic [7:0] code;
      logic       last;
      logic       dig;
      logic       oct;
      logic       bin;
      logic       zero;
      logic       hexd;
      logic       dot;
      logic       sign;
      logic       ux;
      logic       ub;
      logic       uu;
      logic       ul;
      logic       uh;
      logic       uk;
      logic       ur;
      logic       uf;
      logic       up;
      logic       ue;
   } chr_info_type;

   typedef struct packed {
      logic         valid;
      chr_info_type info;
   } q_head_type;

endpackage

// File: rtl/numeric_literal_classifier_unit.sv
// ---------------------------------------------------------------------------
// numeric_literal_classifier_unit
// Classifies a number token, one character per item, as integer, fixed
// point, floating or invalid.
// ---------------------------------------------------------------------------
// Throughput: one character per cycle while req_stall is low; the recognizers
//    update for each character taken from the queue. An accepted character
//    is written to the queue; the class is registered as the last one leaves.
// Input stalls only when the four-entry queue fills behind a stalled result.
// Reset clears the queue, all recognizer phases and the result valid.
module numeric_literal_classifier_unit
   import nlc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_literal_class
);

   logic         queue_full;
   logic         push;
   logic         pop;
   chr_info_type push_info;
   q_head_type   head;

   nlc_front u_front (
      .req_valid     (req_valid),
      .req_char_code (req_char_code),
      .req_is_last   (req_is_last),
      .queue_full    (queue_full),
      .req_stall     (req_stall),
      .push          (push),
      .push_info     (push_info)
   );

   nlc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_info (push_info),
      .pop       (pop),
      .full      (queue_full),
      .head      (head)
   );

   nlc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_literal_class (rsp_literal_class)
   );

endmodule

// File: rtl/nlc_front.sv
// ---------------------------------------------------------------------------
// nlc_front
// Input handshake and character decode ahead of the queue.
// ---------------------------------------------------------------------------
module nlc_front
   import nlc_pkg::*;
(
   input  logic         req_valid,
   input  logic [7:0]   req_char_code,
   input  logic         req_is_last,
   input  logic         queue_full,
   output logic         req_stall,
   output logic         push,
   output chr_info_type push_info
);

   logic [7:0] upper;

   assign upper = (req_char_code >= "a" && req_char_code <= "z") ?
                  (req_char_code - 8'd32) : req_char_code;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_info.code = req_char_code;
      push_info.last = req_is_last;
      push_info.dig  = (req_char_code >= "0") && (req_char_code <= "9");
      push_info.oct  = (req_char_code >= "0") && (req_char_code <= "7");
      push_info.bin  = (req_char_code == "0") || (req_char_code == "1");
      push_info.zero = (req_char_code == "0");
      push_info.hexd = ((req_char_code >= "0") && (req_char_code <= "9")) ||
                       ((upper >= "A") && (upper <= "F"));
      push_info.dot  = (req_char_code == ".");
      push_info.sign = (req_char_code == "+") || (req_char_code == "-");
      push_info.ux   = (upper == "X");
      push_info.ub   = (upper == "B");
      push_info.uu   = (upper == "U");
      push_info.ul   = (upper == "L");
      push_info.uh   = (upper == "H");
      push_info.uk   = (upper == "K");
      push_info.ur   = (upper == "R");
      push_info.uf   = (upper == "F");
      push_info.up   = (upper == "P");
      push_info.ue   = (upper == "E");
   end

endmodule

// File: rtl/nlc_queue.sv
// ---------------------------------------------------------------------------
// nlc_queue
// Small queue of decoded characters between the front and the back.
// ---------------------------------------------------------------------------
module nlc_queue
   import nlc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  chr_info_type push_info,
   input  logic         pop,
   output logic         full,
   output q_head_type   head
);

   chr_info_type           entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.info  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_info;
      end
   end

endmodule

// File: rtl/nlc_back.sv
// ---------------------------------------------------------------------------
// nlc_back
// The three recognizers, the class decision and the result register.
// ---------------------------------------------------------------------------
module nlc_back
   import nlc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  q_head_type  head,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_literal_class
);

   int_phase_type int_ff, int_in;
   fix_phase_type fix_ff, fix_in;
   flt_phase_type flt_ff, flt_in, body_nx, flt_after_nx;
   logic [7:0]    prior_ff, prior_in;
   logic          in_token_ff;
   logic          out_valid_ff, out_valid_in;
   lit_class_type out_class_ff, out_class_in;
   chr_info_type  ch;
   logic          first, in_body, out_free, take, same_prior;

   function automatic fix_phase_type fix_after(fix_phase_type ph, chr_info_type c);
      fix_phase_type res;
      res = FIX_DEAD;
      unique case (ph)
         FIX_BODY: begin
            if (c.uu)              res = FIX_U;
            else if (c.ul || c.uh) res = FIX_LH;
            else if (c.uk || c.ur) res = FIX_KR;
         end
         FIX_U: begin
            if (c.ul || c.uh)      res = FIX_LH;
            else if (c.uk || c.ur) res = FIX_KR;
         end
         FIX_LH: begin
            if (c.uk || c.ur)      res = FIX_KR;
         end
         default: res = FIX_DEAD;
      endcase
      return res;
   endfunction

   assign ch         = head.info;
   assign first      = !in_token_ff;
   assign same_prior = (ch.code == prior_ff);
   assign in_body    = first || (flt_ff <= FLT_EXP);
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign take       = head.valid && (!ch.last || out_free);
   assign pop        = take;

   // Integer recognizer.
   always_comb begin
      int_in = INT_DEAD;
      if (first) begin
         if (ch.zero)     int_in = INT_ZERO;
         else if (ch.dig) int_in = INT_DEC;
      end else begin
         unique case (int_ff)
            INT_ZERO: begin
               if (ch.ux)       int_in = INT_HEX;
               else if (ch.ub)  int_in = INT_BIN;
               else if (ch.oct) int_in = INT_OCT;
               else if (ch.uu)  int_in = INT_U;
               else if (ch.ul)  int_in = INT_L;
            end
            INT_HEX, INT_BIN, INT_OCT, INT_DEC: begin
               if ((int_ff == INT_HEX && ch.hexd) || (int_ff == INT_BIN && ch.bin) ||
                   (int_ff == INT_OCT && ch.oct) || (int_ff == INT_DEC && ch.dig)) begin
                  int_in = int_ff;
               end else if (ch.uu) begin
                  int_in = INT_U;
               end else if (ch.ul) begin
                  int_in = INT_L;
               end
            end
            INT_U: begin
               if (ch.ul) int_in = INT_UL;
            end
            INT_UL: begin
               if (same_prior) int_in = INT_END;
            end
            INT_L: begin
               if (ch.uu)           int_in = INT_END;
               else if (same_prior) int_in = INT_LL;
            end
            INT_LL: begin
               if (ch.uu) int_in = INT_END;
            end
            default: int_in = INT_DEAD;
         endcase
      end
   end

   // Float body move; FLT_BODY_DONE means the character does not continue the body.
   always_comb begin
      body_nx = FLT_BODY_DONE;
      if (first) begin
         if (ch.zero)     body_nx = FLT_ZERO;
         else if (ch.dig) body_nx = FLT_DINT;
         else if (ch.dot) body_nx = FLT_DFRAC;
         else if (ch.ue)  body_nx = FLT_EXP0;
      end else begin
         unique case (flt_ff)
            FLT_ZERO, FLT_DINT: begin
               if (flt_ff == FLT_ZERO && ch.ux) body_nx = FLT_HINT;
               else if (ch.dig)                 body_nx = FLT_DINT;
               else if (ch.dot)                 body_nx = FLT_DFRAC;
               else if (ch.ue)                  body_nx = FLT_EXP0;
            end
            FLT_DFRAC: begin
               if (ch.dig)     body_nx = FLT_DFRAC;
               else if (ch.ue) body_nx = FLT_EXP0;
            end
            FLT_HINT: begin
               if (ch.hexd)     body_nx = FLT_HINT;
               else if (ch.dot) body_nx = FLT_HFRAC;
               else if (ch.up)  body_nx = FLT_EXP0;
            end
            FLT_HFRAC: begin
               if (ch.hexd)    body_nx = FLT_HFRAC;
               else if (ch.up) body_nx = FLT_EXP0;
            end
            FLT_EXP0: begin
               if (ch.sign || ch.dig) body_nx = FLT_EXP;
            end
            FLT_EXP: begin
               if (ch.dig) body_nx = FLT_EXP;
            end
            default: body_nx = FLT_BODY_DONE;
         endcase
      end
   end

   // Float suffix move and the fixed-point recognizer.
   always_comb begin
      flt_after_nx = FLT_DEAD;
      if (in_body) begin
         if (ch.uf)      flt_after_nx = FLT_FIN;
         else if (ch.ul) flt_after_nx = FLT_L;
      end else if (flt_ff == FLT_L) begin
         if (ch.uf)           flt_after_nx = FLT_FIN;
         else if (same_prior) flt_after_nx = FLT_LL;
      end else if (flt_ff == FLT_LL) begin
         if (ch.uf) flt_after_nx = FLT_FIN;
      end

      if (in_body && body_nx != FLT_BODY_DONE) begin
         flt_in = body_nx;
         fix_in = FIX_BODY;
      end else if (in_body) begin
         flt_in = flt_after_nx;
         fix_in = fix_after(FIX_BODY, ch);
      end else begin
         flt_in = flt_after_nx;
         fix_in = fix_after(fix_ff, ch);
      end

      prior_in = prior_ff;
      if (int_in == INT_L || int_in == INT_UL || flt_in == FLT_L) begin
         prior_in = ch.code;
      end
   end

   // Class decision with priority integer, fixed point, float.
   always_comb begin
      if (int_in >= INT_ZERO && int_in <= INT_END) begin
         out_class_in = CLASS_INT;
      end else if (fix_in == FIX_KR) begin
         out_class_in = CLASS_FIX;
      end else if ((flt_in >= FLT_ZERO && flt_in <= FLT_L) || flt_in == FLT_FIN) begin
         out_class_in = CLASS_FLT;
      end else begin
         out_class_in = CLASS_INVALID;
      end

      out_valid_in = out_valid_ff;
      if (take && ch.last) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         int_ff       <= INT_START;
         fix_ff       <= FIX_BODY;
         flt_ff       <= FLT_START;
         prior_ff     <= '0;
         in_token_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            if (ch.last) begin
               int_ff      <= INT_START;
               fix_ff      <= FIX_BODY;
               flt_ff      <= FLT_START;
               prior_ff    <= '0;
               in_token_ff <= 1'b0;
            end else begin
               int_ff      <= int_in;
               fix_ff      <= fix_in;
               flt_ff      <= flt_in;
               prior_ff    <= prior_in;
               in_token_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && ch.last) begin
         out_class_ff <= out_class_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_literal_class = out_class_ff;

endmodule

// File: rtl/nlc_checker.sv
// ---------------------------------------------------------------------------
// nlc_checker
// Port-level checks for the numeric literal classifier, bound to the top.
// ---------------------------------------------------------------------------
`include "numeric_literal_classifier_unit_macros.svh"

module nlc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_literal_class
);

   // A stalled result holds its value.
   `NLC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_literal_class))

   // Reset leaves an empty queue and no pending result.
   `NLC_ASSERT_NEXT_ALWAYS(a_reset_idle, reset, !rsp_valid && !req_stall)

   // The queue can only be full after the result side was blocked.
   `NLC_ASSERT_IMPLY(a_stall_cause, req_stall, $past(rsp_valid && rsp_stall) && rsp_valid)

endmodule

bind numeric_literal_classifier_unit nlc_checker u_nlc_checker (.*);
